// File: src/max_min_times_sum_interval_macros.svh
// ----------------------------------------------------------------------------
// max_min_times_sum_interval assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_TIMES_SUM_INTERVAL_MACROS_SVH
`define MAX_MIN_TIMES_SUM_INTERVAL_MACROS_SVH
`ifndef SYNTH
`define MMTSI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMTSI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMTSI_ASSERT(label, clk, rst_n, prop, msg)
`define MMTSI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/mmtsi_pkg.sv
// ----------------------------------------------------------------------------
// mmtsi_pkg
// Fixed port widths and the saturation limit of the interval product.
// ----------------------------------------------------------------------------
`default_nettype none

package mmtsi_pkg;

  localparam int IN_VALUE_W = 16;
  localparam int PROD_W     = 40;

  localparam logic [PROD_W-1:0] PROD_MAX = '1;

endpackage

`default_nettype wire

// File: src/mmtsi_store.sv
// ----------------------------------------------------------------------------
// mmtsi_store
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmtsi_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/mmtsi_jobq.sv
// ----------------------------------------------------------------------------
// mmtsi_jobq
// Two-entry queue of sequence descriptors between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_min_times_sum_interval_macros.svh"

module mmtsi_jobq #(
  parameter int WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `MMTSI_ASSERT(a_jobq_cnt_range, clk, rst_n, cnt_r <= 2'd2, "job queue count out of range")
  `MMTSI_ASSERT(a_jobq_ptr_match, clk, rst_n, cnt_r != 2'd1 |-> wr_ptr_r == rd_ptr_r, "job queue pointers disagree with count")

endmodule

`default_nettype wire

// File: src/mmtsi_front.sv
// ----------------------------------------------------------------------------
// mmtsi_front
// Takes input items, writes them into the store and hands each finished
// sequence to the back as a descriptor of element count and drop flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mmtsi_front #(
  parameter int MAX_ELEMENTS = 256,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic [mmtsi_pkg::IN_VALUE_W-1:0]         in_value,
  input  wire logic                                     in_last,
  input  wire logic                                     push,
  output logic                                          full,
  input  wire logic                                     jobq_full,
  input  wire logic                                     store_free,
  output logic                                          wr_en,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]          wr_addr,
  output logic      [VALUE_BITS-1:0]                    wr_data,
  output logic                                          job_push,
  output logic      [$clog2(MAX_ELEMENTS+1)-1:0]        job_count,
  output logic                                          job_dropped
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int AW    = $clog2(MAX_ELEMENTS);

  localparam logic F_LOAD = 1'b0;
  localparam logic F_HOLD = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] cnt_inc;

  // While a sequence is being scanned the store is in use, so the front holds.
  assign full    = (state_r == F_HOLD) || jobq_full;
  assign accept  = push && !full;
  assign room    = (cnt_r < CNT_W'(MAX_ELEMENTS));
  assign cnt_inc = cnt_r + CNT_W'(1);

  assign wr_en       = accept && room;
  assign wr_addr     = cnt_r[AW-1:0];
  assign wr_data     = VALUE_BITS'(in_value);
  assign job_push    = accept && in_last;
  assign job_count   = room ? cnt_inc : cnt_r;
  assign job_dropped = drop_r || !room;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      F_LOAD: begin
        if (accept) begin
          if (room) begin
            cnt_nxt = cnt_inc;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = F_HOLD;
          end
        end
      end
      F_HOLD: begin
        if (store_free) begin
          state_nxt = F_LOAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/mmtsi_back.sv
// ----------------------------------------------------------------------------
// mmtsi_back
// Scan engine: for every stored position it widens the interval left and
// right over elements not below the pivot, accumulates pivot times element,
// saturates and keeps the best product, then holds the result for output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_min_times_sum_interval_macros.svh"

module mmtsi_back #(
  parameter int MAX_ELEMENTS = 256,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 job_empty,
  output logic                                      job_pop,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]    job_count,
  input  wire logic                                 job_dropped,
  output logic                                      rd_en,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]      rd_addr,
  input  wire logic [VALUE_BITS-1:0]                rd_data,
  output logic                                      store_free,
  output logic      [mmtsi_pkg::PROD_W-1:0]         out_best_product,
  output logic                                      out_overflow,
  output logic                                      empty,
  input  wire logic                                 pop
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int AW    = $clog2(MAX_ELEMENTS);
  localparam int MUL_W = 2 * VALUE_BITS;
  localparam int ACC_W = MUL_W + CNT_W;
  localparam int CMP_W = (ACC_W > mmtsi_pkg::PROD_W) ? ACC_W : mmtsi_pkg::PROD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIV   = 3'd1;
  localparam logic [2:0] S_PIVL  = 3'd2;
  localparam logic [2:0] S_LEFT  = 3'd3;
  localparam logic [2:0] S_RIGHT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         drop_r, drop_nxt;
  logic [CNT_W-1:0]             pos_r, pos_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [VALUE_BITS-1:0]        pivot_r, pivot_nxt;
  logic [MUL_W-1:0]             mul_r;
  logic                         mul_v_r, mul_v_nxt;
  logic [ACC_W-1:0]             acc_r;
  logic [mmtsi_pkg::PROD_W-1:0] best_r, best_nxt;
  logic [mmtsi_pkg::PROD_W-1:0] res_best_r, res_best_nxt;
  logic                         res_drop_r, res_drop_nxt;
  logic                         res_valid_r, res_valid_nxt;

  logic [CNT_W-1:0]             pos_inc;
  logic [CNT_W-1:0]             pos_dec;
  logic [CNT_W-1:0]             idx_inc;
  logic [CNT_W-1:0]             idx_dec;
  logic                         right_ok;
  logic                         take;
  logic [VALUE_BITS-1:0]        mul_a;
  logic [MUL_W-1:0]             product;
  logic [mmtsi_pkg::PROD_W-1:0] acc_sat;

  assign pos_inc  = pos_r + CNT_W'(1);
  assign pos_dec  = pos_r - CNT_W'(1);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign right_ok = (pos_inc < count_r);
  assign take     = (rd_data >= pivot_r);

  // The pivot itself arrives in the cycle after its read, before pivot_r holds it.
  assign mul_a   = (state_r == S_PIVL) ? rd_data : pivot_r;
  assign product = MUL_W'(mul_a) * MUL_W'(rd_data);

  assign acc_sat = (CMP_W'(acc_r) > CMP_W'(mmtsi_pkg::PROD_MAX)) ?
                   mmtsi_pkg::PROD_MAX : mmtsi_pkg::PROD_W'(acc_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    pivot_nxt     = pivot_r;
    best_nxt      = best_r;
    res_best_nxt  = res_best_r;
    res_drop_nxt  = res_drop_r;
    res_valid_nxt = res_valid_r && !pop;
    mul_v_nxt     = 1'b0;
    job_pop       = 1'b0;
    store_free    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          count_nxt = job_count;
          drop_nxt  = job_dropped;
          pos_nxt   = '0;
          best_nxt  = '0;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        rd_en     = 1'b1;
        rd_addr   = pos_r[AW-1:0];
        state_nxt = S_PIVL;
      end
      S_PIVL: begin
        pivot_nxt = rd_data;
        mul_v_nxt = 1'b1;
        if (pos_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = pos_dec[AW-1:0];
          idx_nxt   = pos_dec;
          state_nxt = S_LEFT;
        end else if (right_ok) begin
          rd_en     = 1'b1;
          rd_addr   = pos_inc[AW-1:0];
          idx_nxt   = pos_inc;
          state_nxt = S_RIGHT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LEFT: begin
        mul_v_nxt = take;
        if (take && idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
          idx_nxt = idx_dec;
        end else if (right_ok) begin
          rd_en     = 1'b1;
          rd_addr   = pos_inc[AW-1:0];
          idx_nxt   = pos_inc;
          state_nxt = S_RIGHT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RIGHT: begin
        mul_v_nxt = take;
        if (take && idx_inc < count_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
          idx_nxt = idx_inc;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // The last product lands in the accumulator during this cycle.
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (acc_sat > best_r) begin
          best_nxt = acc_sat;
        end
        if (right_ok) begin
          pos_nxt   = pos_inc;
          state_nxt = S_PIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid_r || pop) begin
          res_best_nxt  = best_r;
          res_drop_nxt  = drop_r;
          res_valid_nxt = 1'b1;
          store_free    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    drop_r     <= drop_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    pivot_r    <= pivot_nxt;
    best_r     <= best_nxt;
    res_best_r <= res_best_nxt;
    res_drop_r <= res_drop_nxt;
    mul_r      <= product;
    if (state_r == S_PIV) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_v_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_v_r     <= mul_v_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign out_best_product = res_best_r;
  assign out_overflow     = res_drop_r;
  assign empty            = !res_valid_r;

  `MMTSI_ASSERT_ALWAYS(a_back_reset, clk, !rst_n |=> state_r == S_IDLE && !res_valid_r, "back not idle after reset")
  `MMTSI_ASSERT(a_back_result_src, clk, rst_n, $rose(res_valid_r) |-> $past(state_r) == S_OUT, "result appeared outside the output state")
  `MMTSI_ASSERT(a_back_drained, clk, rst_n, state_r == S_IDLE |-> !mul_v_r, "product pending while idle")

endmodule

`default_nettype wire

// File: src/max_min_times_sum_interval.sv
// ----------------------------------------------------------------------------
// max_min_times_sum_interval
// Collects a sequence of unsigned elements and, on the item marked last,
// returns the largest "interval minimum times interval sum" over all
// contiguous intervals, with a flag for elements dropped at a full store.
//
//   channel  direction  handshake            fields
//   in       input      push / full          in_value, in_last
//   out      output     pop / empty          out_best_product, out_overflow
//
// A non-last item is written into the element store as it is taken. The item
// marked last starts a scan that visits every stored position p and reads the
// neighbors of p outward on each side until one is below the pivot, one at a
// time through the single read port of the element store; the back takes the
// sequence from the job queue first and hands its result over at the end.
// full stays high from the last item until the scan ends and its result is
// in the output register. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module max_min_times_sum_interval #(
  parameter int MAX_ELEMENTS = 256,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [mmtsi_pkg::IN_VALUE_W-1:0]     in_value,
  input  wire logic                                 in_last,
  input  wire logic                                 push,
  output logic                                      full,
  output logic      [mmtsi_pkg::PROD_W-1:0]         out_best_product,
  output logic                                      out_overflow,
  output logic                                      empty,
  input  wire logic                                 pop
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int AW    = $clog2(MAX_ELEMENTS);
  localparam int JOB_W = CNT_W + 1;

  logic                  jobq_full;
  logic                  jobq_empty;
  logic                  store_free;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  job_push;
  logic                  job_pop;
  logic [CNT_W-1:0]      front_count;
  logic                  front_dropped;
  logic [JOB_W-1:0]      job_in;
  logic [JOB_W-1:0]      job_out;

  assign job_in = {front_count, front_dropped};

  mmtsi_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_value),
    .in_last     (in_last),
    .push        (push),
    .full        (full),
    .jobq_full   (jobq_full),
    .store_free  (store_free),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_push    (job_push),
    .job_count   (front_count),
    .job_dropped (front_dropped)
  );

  mmtsi_store #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mmtsi_jobq #(
    .WIDTH (JOB_W)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .full    (jobq_full),
    .pop     (job_pop),
    .rd_data (job_out),
    .empty   (jobq_empty)
  );

  mmtsi_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (jobq_empty),
    .job_pop          (job_pop),
    .job_count        (job_out[JOB_W-1:1]),
    .job_dropped      (job_out[0]),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .store_free       (store_free),
    .out_best_product (out_best_product),
    .out_overflow     (out_overflow),
    .empty            (empty),
    .pop              (pop)
  );

endmodule

`default_nettype wire
